// File: rtl/mpmrq_pkg.sv
// Shared constants and types for the multi-port message ring queue.
package mpmrq_pkg;

  localparam int NUM_PORTS_DEF    = 4;
  localparam int MAX_DEPTH_DEF    = 16;
  localparam int HANDLE_WIDTH_DEF = 16;

  localparam int PORT_IN_W   = 2;
  localparam int OCC_W       = 5;
  localparam int CFG_DEPTH_W = 5;
  localparam int CFG_COUNT   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [0:0] {
    CMD_PUSH  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// File: rtl/mpmrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpmrq_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/multi_port_message_ring_queue.sv
// Top level of the multi-port message ring queue.
//
// Usage:
//   Input channel: drive in_command, in_port and in_message_handle with start
//   high; the word is taken at an edge where start is high and busy is low.
//   busy stays low, so a new command can be taken at every clock edge.
//   A push stores the handle at the tail of the addressed port's ring, a fetch
//   returns the oldest handle. A push to a full port reports full, a fetch
//   from an empty port reports empty; neither changes any state.
//   Result channel: exactly one result word per command, shown for one cycle
//   with out_valid high, in the cycle right after the command is taken
//   (throughput 1 command per cycle). The receiver cannot
//   stall; a result not captured in its cycle is gone.
//   The fetched handle comes from the registered read port of the handle store.
//   Configuration: APB registers at byte addresses 0, 4, 8, 12 set the ring
//   depth of ports 0..3 from pwdata[4:0] (0 reads back as 1, values above the maximum
//   saturate). A write empties that port. Write only while idle.
//   Reset (rst_n low, synchronous): all rings empty, all depths at maximum.
module multi_port_message_ring_queue #(
  parameter int NUM_PORTS    = mpmrq_pkg::NUM_PORTS_DEF,
  parameter int MAX_DEPTH    = mpmrq_pkg::MAX_DEPTH_DEF,
  parameter int HANDLE_WIDTH = mpmrq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [mpmrq_pkg::PORT_IN_W-1:0]     in_port,
  input  logic [HANDLE_WIDTH-1:0]             in_message_handle,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [HANDLE_WIDTH-1:0]             out_fetched_handle,
  output logic [mpmrq_pkg::OCC_W-1:0]         out_occupancy,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpmrq_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [mpmrq_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [mpmrq_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int IDX_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
  localparam int SAT_W  = (CNT_W > mpmrq_pkg::CFG_DEPTH_W) ? CNT_W : mpmrq_pkg::CFG_DEPTH_W;
  localparam int STORE_DEPTH = NUM_PORTS * MAX_DEPTH;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [CNT_W-1:0] depth_r   [NUM_PORTS];
  logic [CNT_W-1:0] depth_nxt [NUM_PORTS];
  logic [IDX_W-1:0] head_r    [NUM_PORTS];
  logic [IDX_W-1:0] head_nxt  [NUM_PORTS];
  logic [IDX_W-1:0] tail_r    [NUM_PORTS];
  logic [IDX_W-1:0] tail_nxt  [NUM_PORTS];
  logic [CNT_W-1:0] count_r   [NUM_PORTS];
  logic [CNT_W-1:0] count_nxt [NUM_PORTS];

  logic                    out_valid_r;
  mpmrq_pkg::status_t      status_r, status_nxt;
  logic [CNT_W-1:0]        occ_r, occ_nxt;
  logic                    fetch_ok_r, fetch_ok_nxt;

  logic                    accept;
  logic                    cfg_wr;
  logic [3:0]              cfg_idx_ext;
  logic [SAT_W-1:0]        raw_ext;
  logic [CNT_W-1:0]        depth_wr;
  logic [3:0]              port_ext;
  logic [3:0]              port_red;
  logic [PORT_W-1:0]       p;
  logic [CNT_W-1:0]        sel_depth;
  logic [CNT_W-1:0]        sel_count;
  logic [IDX_W-1:0]        sel_head;
  logic [IDX_W-1:0]        sel_tail;
  logic [CNT_W-1:0]        head_inc;
  logic [CNT_W-1:0]        tail_inc;
  logic [IDX_W-1:0]        head_adv;
  logic [IDX_W-1:0]        tail_adv;
  logic                    is_push;
  logic                    push_ok;
  logic                    fetch_ok;
  logic [ADDR_W-1:0]       base_addr;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [HANDLE_WIDTH-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign cfg_idx_ext = 4'(paddr[mpmrq_pkg::CFG_ADDR_W-1:2]);

  // Saturate the written depth into 1..MAX_DEPTH.
  assign raw_ext = SAT_W'(pwdata[mpmrq_pkg::CFG_DEPTH_W-1:0]);
  always_comb begin
    if (raw_ext == '0) begin
      depth_wr = CNT_W'(1);
    end else if (raw_ext > SAT_W'(MAX_DEPTH)) begin
      depth_wr = CNT_W'(MAX_DEPTH);
    end else begin
      depth_wr = CNT_W'(raw_ext);
    end
  end

  always_comb begin
    prdata = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (i < mpmrq_pkg::CFG_COUNT && cfg_idx_ext == 4'(i)) begin
        prdata = mpmrq_pkg::CFG_DATA_W'(depth_r[i]);
      end
    end
  end

  // Fold the port number into range.
  assign port_ext = 4'(in_port);
  always_comb begin
    if (NUM_PORTS == 1) begin
      port_red = '0;
    end else if (port_ext >= 4'(NUM_PORTS)) begin
      port_red = port_ext - 4'(NUM_PORTS);
    end else begin
      port_red = port_ext;
    end
  end
  assign p = port_red[PORT_W-1:0];

  assign sel_depth = depth_r[p];
  assign sel_count = count_r[p];
  assign sel_head  = head_r[p];
  assign sel_tail  = tail_r[p];

  assign head_inc = CNT_W'(sel_head) + CNT_W'(1);
  assign tail_inc = CNT_W'(sel_tail) + CNT_W'(1);
  assign head_adv = (head_inc >= sel_depth) ? '0 : IDX_W'(head_inc);
  assign tail_adv = (tail_inc >= sel_depth) ? '0 : IDX_W'(tail_inc);

  assign is_push  = (mpmrq_pkg::cmd_t'(in_command) == mpmrq_pkg::CMD_PUSH);
  assign push_ok  = is_push && (sel_count < sel_depth);
  assign fetch_ok = !is_push && (sel_count != '0);

  assign base_addr = ADDR_W'(p) * ADDR_W'(MAX_DEPTH);
  assign ram_waddr = base_addr + ADDR_W'(sel_tail);
  assign ram_raddr = base_addr + ADDR_W'(sel_head);

  always_comb begin
    depth_nxt = depth_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cfg_wr) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        if (i < mpmrq_pkg::CFG_COUNT && cfg_idx_ext == 4'(i)) begin
          depth_nxt[i] = depth_wr;
          head_nxt[i]  = '0;
          tail_nxt[i]  = '0;
          count_nxt[i] = '0;
        end
      end
    end else if (accept) begin
      if (push_ok) begin
        tail_nxt[p]  = tail_adv;
        count_nxt[p] = sel_count + CNT_W'(1);
      end else if (fetch_ok) begin
        head_nxt[p]  = head_adv;
        count_nxt[p] = sel_count - CNT_W'(1);
      end
    end
  end

  always_comb begin
    status_nxt   = mpmrq_pkg::ST_OK;
    occ_nxt      = sel_count;
    fetch_ok_nxt = fetch_ok;
    if (is_push) begin
      if (push_ok) begin
        occ_nxt = sel_count + CNT_W'(1);
      end else begin
        status_nxt = mpmrq_pkg::ST_FULL;
      end
    end else begin
      if (fetch_ok) begin
        occ_nxt = sel_count - CNT_W'(1);
      end else begin
        status_nxt = mpmrq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        depth_r[i] <= CNT_W'(MAX_DEPTH);
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      occ_r      <= occ_nxt;
      fetch_ok_r <= fetch_ok_nxt;
    end
  end

  mpmrq_ram #(
    .WIDTH  (HANDLE_WIDTH),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && push_ok),
    .waddr (ram_waddr),
    .wdata (in_message_handle),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_fetched_handle = fetch_ok_r ? ram_rdata : '0;
  assign out_occupancy      = mpmrq_pkg::OCC_W'(occ_r);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("missing result word");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid_r)
    else $error("result word without command");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == mpmrq_pkg::ST_EMPTY) |-> (occ_r == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == mpmrq_pkg::ST_FULL) |-> (occ_r != '0))
    else $error("full status with zero occupancy");

  for (genvar g = 0; g < NUM_PORTS; g++) begin : g_chk
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r[g] <= depth_r[g]) && (CNT_W'(head_r[g]) < depth_r[g])
        && (CNT_W'(tail_r[g]) < depth_r[g]))
      else $error("ring pointer or count beyond depth");
  end

endmodule
